// ===== sv/dccm_pkg.sv =====
// Shared types and constants of the disc coverage count map.
// No dependencies; every module of the block imports this package.
`default_nettype none

package dccm_pkg;

   localparam int OPCODE_W    = 2;
   localparam int POS_W       = 8;
   localparam int RADIUS_W    = 7;
   localparam int RR_W        = 2 * RADIUS_W;
   localparam int COUNT_OUT_W = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int COORD_W     = 10;
   localparam int CALC_W      = 12;
   localparam int QUEUE_DEPTH = 2;

   localparam int DEF_MAX_COLS   = 128;
   localparam int DEF_MAX_ROWS   = 128;
   localparam int DEF_COUNT_BITS = 16;

   localparam logic [CSR_DATA_W-1:0] MAP_COLS_RESET = CSR_DATA_W'(128);
   localparam logic [CSR_DATA_W-1:0] MAP_ROWS_RESET = CSR_DATA_W'(128);

   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_COLS = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_ROWS = CSR_INDEX_W'(1);

   localparam logic [OPCODE_W-1:0] OP_ADD    = OPCODE_W'(0);
   localparam logic [OPCODE_W-1:0] OP_REMOVE = OPCODE_W'(1);
   localparam logic [OPCODE_W-1:0] OP_QUERY  = OPCODE_W'(2);

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_INC,
      KIND_DEC,
      KIND_QUERY
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic               outside;
      logic [COORD_W-1:0] cx;
      logic [COORD_W-1:0] cy;
      logic [COORD_W-1:0] x0;
      logic [COORD_W-1:0] x1;
      logic [COORD_W-1:0] y0;
      logic [COORD_W-1:0] y1;
      logic [RR_W-1:0]    rr;
   } q_entry_type;

endpackage

`default_nettype wire

// ===== sv/dccm_front.sv =====
// Front end: grid size registers, input acceptance and window clipping.
// Depends on dccm_pkg; feeds dccm_queue.
`default_nettype none

module dccm_front #(
   parameter int MAX_COLS = dccm_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = dccm_pkg::DEF_MAX_ROWS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write_enable,
   input  wire logic [dccm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [dccm_pkg::CSR_DATA_W-1:0]    csr_write_data,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [dccm_pkg::OPCODE_W-1:0]      req_opcode,
   input  wire logic [dccm_pkg::POS_W-1:0]         req_center_x,
   input  wire logic [dccm_pkg::POS_W-1:0]         req_center_y,
   input  wire logic [dccm_pkg::RADIUS_W-1:0]      req_radius_cells,
   input  wire logic                               clearing,
   input  wire logic                               push_ready,
   output logic                                    push_valid,
   output dccm_pkg::q_entry_type                   push_entry
);
   import dccm_pkg::*;

   logic [CSR_DATA_W-1:0] map_cols_ff, map_cols_in;
   logic [CSR_DATA_W-1:0] map_rows_ff, map_rows_in;

   logic [CALC_W-1:0] cols, rows, cx, cy, r;
   logic [CALC_W-1:0] xlo, xhi_raw, xhi, ylo, yhi_raw, yhi;
   logic              x_empty, y_empty, disc_none, query_out;

   always_comb begin
      map_cols_in = map_cols_ff;
      map_rows_in = map_rows_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_MAP_COLS: map_cols_in = csr_write_data;
            CSR_MAP_ROWS: map_rows_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_cols_ff <= MAP_COLS_RESET;
         map_rows_ff <= MAP_ROWS_RESET;
      end else begin
         map_cols_ff <= map_cols_in;
         map_rows_ff <= map_rows_in;
      end
   end

   always_comb begin
      cols = (CALC_W'(map_cols_ff) > CALC_W'(MAX_COLS)) ? CALC_W'(MAX_COLS)
                                                         : CALC_W'(map_cols_ff);
      rows = (CALC_W'(map_rows_ff) > CALC_W'(MAX_ROWS)) ? CALC_W'(MAX_ROWS)
                                                         : CALC_W'(map_rows_ff);
      cx = CALC_W'(req_center_x);
      cy = CALC_W'(req_center_y);
      r  = CALC_W'(req_radius_cells);

      xlo     = (cx > r) ? cx - r : '0;
      xhi_raw = cx + r;
      xhi     = (xhi_raw >= cols) ? cols - CALC_W'(1) : xhi_raw;
      ylo     = (cy > r) ? cy - r : '0;
      yhi_raw = cy + r;
      yhi     = (yhi_raw >= rows) ? rows - CALC_W'(1) : yhi_raw;

      x_empty   = (cols == '0) || (xlo > xhi);
      y_empty   = (rows == '0) || (ylo > yhi);
      disc_none = (r == '0) || x_empty || y_empty;
      query_out = (cx >= cols) || (cy >= rows);

      push_entry.kind    = KIND_NONE;
      push_entry.outside = 1'b0;
      push_entry.cx      = COORD_W'(req_center_x);
      push_entry.cy      = COORD_W'(req_center_y);
      push_entry.x0      = xlo[COORD_W-1:0];
      push_entry.x1      = xhi[COORD_W-1:0];
      push_entry.y0      = ylo[COORD_W-1:0];
      push_entry.y1      = yhi[COORD_W-1:0];
      push_entry.rr      = RR_W'(req_radius_cells) * RR_W'(req_radius_cells);

      case (req_opcode)
         OP_ADD:    push_entry.kind = disc_none ? KIND_NONE : KIND_INC;
         OP_REMOVE: push_entry.kind = disc_none ? KIND_NONE : KIND_DEC;
         OP_QUERY: begin
            push_entry.outside = query_out;
            push_entry.kind    = query_out ? KIND_NONE : KIND_QUERY;
            push_entry.x0      = COORD_W'(req_center_x);
            push_entry.x1      = COORD_W'(req_center_x);
            push_entry.y0      = COORD_W'(req_center_y);
            push_entry.y1      = COORD_W'(req_center_y);
         end
         default: push_entry.kind = KIND_NONE;
      endcase
   end

   assign req_ready  = !clearing && push_ready;
   assign push_valid = req_valid && req_ready;

endmodule

`default_nettype wire

// ===== sv/dccm_queue.sv =====
// Short item queue between the front end and the cell walker.
// Depends on dccm_pkg for the entry type and depth.
`default_nettype none

module dccm_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push_valid,
   output logic                       push_ready,
   input  wire dccm_pkg::q_entry_type push_entry,
   output logic                       pop_valid,
   input  wire logic                  pop_ready,
   output dccm_pkg::q_entry_type      pop_entry
);
   import dccm_pkg::*;

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   q_entry_type         entries_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = (count_ff != CntW'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== sv/dccm_back.sv =====
// Back end: counter memory, clearing pass, cell walker with read-modify-write
// pipeline, and the result register. Depends on dccm_pkg.
`default_nettype none

module dccm_back #(
   parameter int MAX_COLS   = dccm_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS   = dccm_pkg::DEF_MAX_ROWS,
   parameter int COUNT_BITS = dccm_pkg::DEF_COUNT_BITS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              pop_valid,
   output logic                                   pop_ready,
   input  wire dccm_pkg::q_entry_type             pop_entry,
   output logic                                   clearing,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [dccm_pkg::COUNT_OUT_W-1:0]       rsp_coverage_count,
   output logic                                   rsp_outside_map
);
   import dccm_pkg::*;

   localparam int Cells = MAX_COLS * MAX_ROWS;
   localparam int AW    = $clog2(Cells);
   localparam int XW    = $clog2(MAX_COLS);
   localparam int YW    = $clog2(MAX_ROWS);
   localparam int LowW  = (COUNT_BITS < COUNT_OUT_W) ? COUNT_BITS : COUNT_OUT_W;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_WALK  = 5'b00100,
      ST_FLUSH = 5'b01000,
      ST_REPLY = 5'b10000
   } state_type;

   logic [COUNT_BITS-1:0] mem [Cells];

   state_type             state_ff, state_in;
   logic [AW-1:0]         clr_addr_ff, clr_addr_in;
   q_entry_type           cur_ff, cur_in;
   logic [XW-1:0]         x_ff, x_in;
   logic [YW-1:0]         y_ff, y_in;
   logic                  s1_valid_ff, s1_valid_in;
   logic [AW-1:0]         s1_addr_ff;
   logic [RR_W-1:0]       s1_dx2_ff, s1_dy2_ff;
   logic [COUNT_BITS-1:0] rd_ff;
   logic [COUNT_OUT_W-1:0] res_count_ff, res_count_in;
   logic                  res_outside_ff, res_outside_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff;
   logic                  rsp_outside_ff;
   logic                  rsp_load;

   logic [AW-1:0]         walk_addr;
   logic [COORD_W-1:0]    x_ext, y_ext, ax_wide, ay_wide;
   logic [RADIUS_W-1:0]   ax, ay;
   logic [RR_W-1:0]       dx2, dy2;
   logic                  is_last, hit, disc_kind, s1_write;
   logic [COUNT_BITS-1:0] new_count;
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [COUNT_BITS-1:0] mem_wdata;

   always_comb begin
      walk_addr = AW'(y_ff) * AW'(MAX_COLS) + AW'(x_ff);
      x_ext     = COORD_W'(x_ff);
      y_ext     = COORD_W'(y_ff);
      ax_wide   = (x_ext >= cur_ff.cx) ? x_ext - cur_ff.cx : cur_ff.cx - x_ext;
      ay_wide   = (y_ext >= cur_ff.cy) ? y_ext - cur_ff.cy : cur_ff.cy - y_ext;
      ax        = ax_wide[RADIUS_W-1:0];
      ay        = ay_wide[RADIUS_W-1:0];
      dx2       = RR_W'(ax) * RR_W'(ax);
      dy2       = RR_W'(ay) * RR_W'(ay);
      is_last   = (x_ff == cur_ff.x1[XW-1:0]) && (y_ff == cur_ff.y1[YW-1:0]);

      hit       = ((RR_W+1)'(s1_dx2_ff) + (RR_W+1)'(s1_dy2_ff)) <= (RR_W+1)'(cur_ff.rr);
      disc_kind = (cur_ff.kind == KIND_INC) || (cur_ff.kind == KIND_DEC);
      s1_write  = s1_valid_ff && disc_kind && hit;

      new_count = rd_ff;
      if (cur_ff.kind == KIND_INC) begin
         if (rd_ff != '1) new_count = rd_ff + COUNT_BITS'(1);
      end else if (rd_ff != '0) begin
         new_count = rd_ff - COUNT_BITS'(1);
      end

      mem_we    = (state_ff == ST_CLEAR) || s1_write;
      mem_waddr = (state_ff == ST_CLEAR) ? clr_addr_ff : s1_addr_ff;
      mem_wdata = (state_ff == ST_CLEAR) ? '0 : new_count;
   end

   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      cur_in         = cur_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      res_count_in   = res_count_ff;
      res_outside_in = res_outside_ff;
      s1_valid_in    = (state_ff == ST_WALK);
      rsp_load       = 1'b0;
      pop_ready      = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(Cells - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               cur_in         = pop_entry;
               res_count_in   = '0;
               res_outside_in = pop_entry.outside;
               x_in           = pop_entry.x0[XW-1:0];
               y_in           = pop_entry.y0[YW-1:0];
               state_in       = (pop_entry.kind == KIND_NONE) ? ST_REPLY : ST_WALK;
            end
         end
         ST_WALK: begin
            if (is_last) begin
               state_in = ST_FLUSH;
            end else if (x_ff == cur_ff.x1[XW-1:0]) begin
               x_in = cur_ff.x0[XW-1:0];
               y_in = y_ff + YW'(1);
            end else begin
               x_in = x_ff + XW'(1);
            end
         end
         ST_FLUSH: begin
            if (cur_ff.kind == KIND_QUERY) begin
               res_count_in = COUNT_OUT_W'(rd_ff[LowW-1:0]);
            end
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      x_ff           <= x_in;
      y_ff           <= y_in;
      s1_addr_ff     <= walk_addr;
      s1_dx2_ff      <= dx2;
      s1_dy2_ff      <= dy2;
      res_count_ff   <= res_count_in;
      res_outside_ff <= res_outside_in;
      if (rsp_load) begin
         rsp_count_ff   <= res_count_ff;
         rsp_outside_ff <= res_outside_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[walk_addr];
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   assign clearing           = (state_ff == ST_CLEAR);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_coverage_count = rsp_count_ff;
   assign rsp_outside_map    = rsp_outside_ff;

   a_walk_in_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (x_ff <= cur_ff.x1[XW-1:0]) && (y_ff <= cur_ff.y1[YW-1:0]))
      else $error("walker left its window");

   a_write_when_busy: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_CLEAR) || (state_ff == ST_WALK) || (state_ff == ST_FLUSH))
      else $error("counter write outside a walk or clearing pass");

   a_stage_follows_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |=> s1_valid_ff)
      else $error("pipeline stage lost a walked cell");

   a_clear_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |=> (state_ff == ST_CLEAR) || (state_ff == ST_IDLE))
      else $error("clearing pass left early");

endmodule

`default_nettype wire

// ===== sv/disc_coverage_count_map_unit.sv =====
// Top level of the disc coverage count map: front end, item queue and back end.
// Depends on dccm_pkg, dccm_front, dccm_queue and dccm_back.
//
// A grid of MAX_COLS x MAX_ROWS saturating counters of COUNT_BITS bits. An add
// or remove item changes every cell of the clipped window that lies within the
// disc; a query item returns one counter, or flags a cell beyond the grid set
// by map_cols and map_rows. Every item gives one result, in order. After reset
// the counter memory is cleared one cell a cycle, all MAX_COLS * MAX_ROWS cells,
// with req_ready low; grid size writes are taken throughout. The counter memory
// has one read and one write port, and the back end takes one item at a time:
// a disc gets one read-modify-write a cell of its clipped window, a query inside
// the grid one read, and an item that needs no walk (zero radius, empty window,
// unused opcode, query beyond the grid) none; each result may wait on rsp_ready.
// A two-entry queue lets new items be accepted while a walk runs.
`default_nettype none

module disc_coverage_count_map_unit #(
   parameter int MAX_COLS   = dccm_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS   = dccm_pkg::DEF_MAX_ROWS,
   parameter int COUNT_BITS = dccm_pkg::DEF_COUNT_BITS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_enable,
   input  wire logic [dccm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [dccm_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [dccm_pkg::OPCODE_W-1:0]     req_opcode,
   input  wire logic [dccm_pkg::POS_W-1:0]        req_center_x,
   input  wire logic [dccm_pkg::POS_W-1:0]        req_center_y,
   input  wire logic [dccm_pkg::RADIUS_W-1:0]     req_radius_cells,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [dccm_pkg::COUNT_OUT_W-1:0]       rsp_coverage_count,
   output logic                                   rsp_outside_map
);
   import dccm_pkg::*;

   logic        clearing;
   logic        push_valid, push_ready, pop_valid, pop_ready;
   q_entry_type push_entry, pop_entry;

   dccm_front #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_center_x     (req_center_x),
      .req_center_y     (req_center_y),
      .req_radius_cells (req_radius_cells),
      .clearing         (clearing),
      .push_ready       (push_ready),
      .push_valid       (push_valid),
      .push_entry       (push_entry)
   );

   dccm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   dccm_back #(
      .MAX_COLS   (MAX_COLS),
      .MAX_ROWS   (MAX_ROWS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .pop_valid          (pop_valid),
      .pop_ready          (pop_ready),
      .pop_entry          (pop_entry),
      .clearing           (clearing),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_coverage_count (rsp_coverage_count),
      .rsp_outside_map    (rsp_outside_map)
   );

endmodule

`default_nettype wire
